/* rtl/core/srhf_pkg.sv */
// package for the sensor report hex framer
// record and character types, ascii constants, hex digit encoder; no dependencies
`timescale 1ns / 1ps

package srhf_pkg;

  localparam int FieldW          = 24;
  localparam int NibCount        = FieldW / 4;
  localparam int MaxHexDigitsDef = 6;

  localparam logic [6:0] CharZero   = 7'h30;
  localparam logic [6:0] CharA      = 7'h41;
  localparam logic [6:0] HeaderChar = 7'h32;

  typedef struct packed {
    logic [FieldW-1:0] battery_level;
    logic [FieldW-1:0] temperature_value;
    logic [FieldW-1:0] latitude_value;
    logic [FieldW-1:0] longitude_value;
    logic [FieldW-1:0] volume_value;
    logic [FieldW-1:0] angle_value;
  } rec_t;

  typedef struct packed {
    logic [6:0] frame_char;
    logic       frame_last;
  } char_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] ch;
    if (nib < 4'd10) begin
      ch = CharZero + {3'b000, nib};
    end else begin
      ch = CharA + {3'b000, nib} - 7'd10;
    end
    return ch;
  endfunction

endpackage

/* rtl/core/srhf_front.sv */
// front part: takes records, clamps fixed fields and sizes the minimal fields
// depends on srhf_pkg; feeds srhf_queue
`timescale 1ns / 1ps

module srhf_front #(
  parameter int MaxHexDigits = srhf_pkg::MaxHexDigitsDef,
  parameter int JobW         = 16 + 16 * MaxHexDigits + 2 * $clog2(MaxHexDigits)
) (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  srhf_pkg::rec_t   in_data_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output logic [JobW-1:0]  q_data_o
);
  import srhf_pkg::*;

  localparam int LW = 4 * MaxHexDigits;
  localparam int DW = $clog2(MaxHexDigits);
  localparam logic [2:0] DigMax = 3'(MaxHexDigits - 1);

  typedef struct packed {
    logic [7:0]    bat;
    logic [7:0]    tmp;
    logic [LW-1:0] lat;
    logic [LW-1:0] lon;
    logic [LW-1:0] vol;
    logic [LW-1:0] ang;
    logic [DW-1:0] vol_top;
    logic [DW-1:0] ang_top;
  } job_t;

  job_t job;
  logic [31:0] lat32, lon32, vol32, ang32;
  logic [2:0]  vol_top, ang_top;

  assign lat32 = {8'b0, in_data_i.latitude_value};
  assign lon32 = {8'b0, in_data_i.longitude_value};
  assign vol32 = {8'b0, in_data_i.volume_value};
  assign ang32 = {8'b0, in_data_i.angle_value};

  // highest nonzero nibble, capped at MaxHexDigits - 1
  always_comb begin
    vol_top = '0;
    ang_top = '0;
    for (int i = 0; i < NibCount; i++) begin
      if (in_data_i.volume_value[4*i +: 4] != 4'd0) vol_top = 3'(i);
      if (in_data_i.angle_value[4*i +: 4] != 4'd0) ang_top = 3'(i);
    end
    if (vol_top > DigMax) vol_top = DigMax;
    if (ang_top > DigMax) ang_top = DigMax;
  end

  always_comb begin
    job.bat = (in_data_i.battery_level[FieldW-1:8] != '0) ? 8'd0
                                                           : in_data_i.battery_level[7:0];
    job.tmp = (in_data_i.temperature_value[FieldW-1:8] != '0) ? 8'd0
                                                               : in_data_i.temperature_value[7:0];
    job.lat = ((lat32 >> LW) != 32'd0) ? '0 : lat32[LW-1:0];
    job.lon = ((lon32 >> LW) != 32'd0) ? '0 : lon32[LW-1:0];
    job.vol = vol32[LW-1:0];
    job.ang = ang32[LW-1:0];
    job.vol_top = vol_top[DW-1:0];
    job.ang_top = ang_top[DW-1:0];
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_data_o   = job;

endmodule

/* rtl/core/srhf_queue.sv */
// two-entry queue of classified records between front and back
// no package dependencies
`timescale 1ns / 1ps

module srhf_queue #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o
);

  localparam int Depth = 2;

  logic [Width-1:0] mem_q [Depth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'(Depth));
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(Depth)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'(Depth)) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");

endmodule

/* rtl/core/srhf_back.sv */
// back part: walks the frame segments and emits one character per transfer
// depends on srhf_pkg; drains srhf_queue
`timescale 1ns / 1ps

module srhf_back #(
  parameter int MaxHexDigits = srhf_pkg::MaxHexDigitsDef,
  parameter int JobW         = 16 + 16 * MaxHexDigits + 2 * $clog2(MaxHexDigits)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  logic [JobW-1:0]  q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output srhf_pkg::char_t  out_data_o
);
  import srhf_pkg::*;

  localparam int LW = 4 * MaxHexDigits;
  localparam int DW = $clog2(MaxHexDigits);
  localparam logic [DW-1:0] DigMax = DW'(MaxHexDigits - 1);

  typedef struct packed {
    logic [7:0]    bat;
    logic [7:0]    tmp;
    logic [LW-1:0] lat;
    logic [LW-1:0] lon;
    logic [LW-1:0] vol;
    logic [LW-1:0] ang;
    logic [DW-1:0] vol_top;
    logic [DW-1:0] ang_top;
  } job_t;

  typedef enum logic [8:0] {
    SegHdr = 9'b000000001,
    SegBat = 9'b000000010,
    SegTmp = 9'b000000100,
    SegLat = 9'b000001000,
    SegLon = 9'b000010000,
    SegSep = 9'b000100000,
    SegVol = 9'b001000000,
    SegAng = 9'b010000000,
    SegEnd = 9'b100000000
  } seg_e;

  job_t          job_q;
  seg_e          seg_q, seg_nxt;
  logic [DW-1:0] dig_q, dig_nxt;
  logic          busy_q, out_valid_q;
  char_t         out_data_q;
  logic [3:0]    nib;
  logic [6:0]    ch;
  logic          last, emit, load;

  always_comb begin
    nib     = 4'd0;
    ch      = CharZero;
    last    = 1'b0;
    seg_nxt = seg_q;
    dig_nxt = (dig_q == '0) ? '0 : dig_q - DW'(1);
    case (seg_q)
      SegHdr: begin
        ch      = HeaderChar;
        seg_nxt = SegBat;
        dig_nxt = DW'(1);
      end
      SegBat: begin
        nib = job_q.bat[{dig_q[0], 2'b00} +: 4];
        ch  = hex_char(nib);
        if (dig_q == '0) begin
          seg_nxt = SegTmp;
          dig_nxt = DW'(1);
        end
      end
      SegTmp: begin
        nib = job_q.tmp[{dig_q[0], 2'b00} +: 4];
        ch  = hex_char(nib);
        if (dig_q == '0) begin
          seg_nxt = SegLat;
          dig_nxt = DigMax;
        end
      end
      SegLat: begin
        nib = job_q.lat[{dig_q, 2'b00} +: 4];
        ch  = hex_char(nib);
        if (dig_q == '0) begin
          seg_nxt = SegLon;
          dig_nxt = DigMax;
        end
      end
      SegLon: begin
        nib = job_q.lon[{dig_q, 2'b00} +: 4];
        ch  = hex_char(nib);
        if (dig_q == '0) seg_nxt = SegSep;
      end
      SegSep: begin
        ch      = CharZero;
        seg_nxt = SegVol;
        dig_nxt = job_q.vol_top;
      end
      SegVol: begin
        nib = job_q.vol[{dig_q, 2'b00} +: 4];
        ch  = hex_char(nib);
        if (dig_q == '0) begin
          seg_nxt = SegAng;
          dig_nxt = job_q.ang_top;
        end
      end
      SegAng: begin
        nib = job_q.ang[{dig_q, 2'b00} +: 4];
        ch  = hex_char(nib);
        if (dig_q == '0) seg_nxt = SegEnd;
      end
      SegEnd: begin
        ch   = CharZero;
        last = 1'b1;
      end
      default: begin
        ch   = CharZero;
        last = 1'b1;
      end
    endcase
  end

  assign emit    = busy_q && (!out_valid_q || !out_stall_i);
  assign load    = q_valid_i && (!busy_q || (emit && last));
  assign q_pop_o = load;

  always_ff @(posedge clk_i) begin
    if (load) job_q <= q_data_i;
    if (emit) begin
      out_data_q.frame_char <= ch;
      out_data_q.frame_last <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      seg_q       <= SegHdr;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        seg_q  <= SegHdr;
      end else if (emit) begin
        if (last) busy_q <= 1'b0;
        seg_q <= seg_nxt;
        dig_q <= dig_nxt;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_reload_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && busy_q) |-> (emit && seg_q == SegEnd)) else $error("reload mid frame");
  a_idle_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && seg_q == SegEnd && !q_valid_i) |=> !busy_q) else $error("busy after last");
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> dig_q <= DigMax) else $error("digit index out of range");

endmodule

/* rtl/core/sensor_report_hex_framer.sv */
// top level of the sensor report hex framer
// depends on srhf_pkg, srhf_front, srhf_queue and srhf_back
//
// usage: one sensor record is a transfer on the in channel (in_valid_i,
// in_stall_o, in_data_i). the frame leaves as ascii characters, one per
// transfer on the out channel (out_valid_o, out_stall_i, out_data_o), with
// frame_last set on the closing character.
// frame length is 9 + 2*MaxHexDigits up to 7 + 4*MaxHexDigits characters
// (21 to 31 at the default of 6 digits).
// path: a record passes the queue, the back sequencer's job register and the output
// register before its first character is valid.
// throughput: one character per cycle while out_stall_i is low; frames follow each
// other with no gap when the next record is already queued. the output register
// and the back sequencer set that rate.
// a two-entry queue holds records taken while a frame is still going out;
// in_stall_o rises when it is full.
// when out_stall_i is high the current character holds and the sequencer
// waits. reset clears the queue, the sequencer and out_valid_o; no state is
// kept between records.
`timescale 1ns / 1ps

module sensor_report_hex_framer #(
  parameter int MaxHexDigits = srhf_pkg::MaxHexDigitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  srhf_pkg::rec_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output srhf_pkg::char_t out_data_o
);
  import srhf_pkg::*;

  localparam int JobW = 16 + 16 * MaxHexDigits + 2 * $clog2(MaxHexDigits);

  logic            q_push, q_full, q_valid, q_pop;
  logic [JobW-1:0] q_wdata, q_rdata;

  srhf_front #(
    .MaxHexDigits(MaxHexDigits),
    .JobW        (JobW)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  srhf_queue #(
    .Width(JobW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_rdata)
  );

  srhf_back #(
    .MaxHexDigits(MaxHexDigits),
    .JobW        (JobW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* bench/srhf_frame_checker.sv */
// checker for the sensor report hex framer: watches both channels, builds the
// expected ascii frame for every record transfer and compares each character
// depends on srhf_pkg
`timescale 1ns / 1ps

module srhf_frame_checker #(
  parameter int MaxDigits = srhf_pkg::MaxHexDigitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  srhf_pkg::rec_t  in_data_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  srhf_pkg::char_t out_data_i,
  output int              error_count_o,
  output int              pending_o
);

  import srhf_pkg::*;

  char_t frame_chars_q[$];
  int    mismatches;
  int    char_index;

  assign error_count_o = mismatches;

  function automatic int unsigned hex_len(input logic [FieldW-1:0] v);
    logic [31:0] w;
    int unsigned n;
    w = 32'(v);
    n = 1;
    while (n < 8 && (w >> (4 * n)) != 0) begin
      n++;
    end
    return n;
  endfunction

  function automatic logic [6:0] nibble_to_ascii(input logic [3:0] d);
    return (d > 4'd9) ? 7'(CharA - 7'd10 + 7'(d)) : 7'(CharZero + 7'(d));
  endfunction

  task automatic push_char(input logic [6:0] c, input logic last);
    frame_chars_q.push_back('{frame_char: c, frame_last: last});
  endtask

  task automatic push_digits(input logic [FieldW-1:0] v, input int unsigned len);
    for (int i = int'(len) - 1; i >= 0; i--) begin
      push_char(nibble_to_ascii(v[4*i +: 4]), 1'b0);
    end
  endtask

  task automatic push_fixed(input logic [FieldW-1:0] v, input int unsigned width);
    if (hex_len(v) > width) begin
      // field too wide: whole field goes out as zeros
      repeat (width) push_char(CharZero, 1'b0);
    end else begin
      push_digits(v, width);
    end
  endtask

  task automatic push_minimal(input logic [FieldW-1:0] v);
    int unsigned len;
    len = hex_len(v);
    if (len > MaxDigits) begin
      len = MaxDigits;
    end
    push_digits(v, len);
  endtask

  task automatic build_frame(input rec_t r);
    push_char(HeaderChar, 1'b0);
    push_fixed(r.battery_level, 2);
    push_fixed(r.temperature_value, 2);
    push_fixed(r.latitude_value, MaxDigits);
    push_fixed(r.longitude_value, MaxDigits);
    push_char(CharZero, 1'b0);
    push_minimal(r.volume_value);
    push_minimal(r.angle_value);
    push_char(CharZero, 1'b1);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at char %0d: %s got 0x%0h expected 0x%0h", char_index, what, got,
             want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    char_index = 0;
    pending_o  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    char_t seen;
    char_t want;
    if (!rst_ni) begin
      frame_chars_q.delete();
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        build_frame(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        seen = out_data_i;
        if (frame_chars_q.size() == 0) begin
          report_mismatch("unexpected character", int'(seen), 0);
        end else begin
          want = frame_chars_q.pop_front();
          if (seen.frame_char !== want.frame_char) begin
            report_mismatch("frame_char", int'(seen.frame_char), int'(want.frame_char));
          end
          if (seen.frame_last !== want.frame_last) begin
            report_mismatch("frame_last", int'(seen.frame_last), int'(want.frame_last));
          end
        end
        char_index++;
      end
      pending_o = frame_chars_q.size();
    end
  end

endmodule

/* bench/sensor_report_hex_framer_test.sv */
// testbench top for the sensor report hex framer: drives records with random
// gaps and stalls, directed corner records first, verdict from srhf_frame_checker
// depends on srhf_pkg, sensor_report_hex_framer and srhf_frame_checker
`timescale 1ns / 1ps

module sensor_report_hex_framer_test;

  import srhf_pkg::*;

  localparam int CycleLimit = 4000000;
  localparam int RandomRecords = 450;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  rec_t  in_data;
  logic  out_valid;
  logic  out_stall;
  char_t out_data;

  int error_count;
  int pending;
  int cycles;
  bit quiet;
  bit hold_go;
  int hold_left;
  int stall_left;

  sensor_report_hex_framer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  srhf_frame_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver side: random stalls, plus a long hold on request
  initial begin
    int pick;
    bit hold_seen;
    out_stall  = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    hold_seen  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_seen) begin
        hold_left = 300;
        hold_seen = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet) begin
          pick = $urandom_range(0, 99);
          if (pick < 15) begin
            stall_left = $urandom_range(1, 3);
          end else if (pick < 17) begin
            stall_left = $urandom_range(15, 50);
          end
        end
      end
    end
  end

  function automatic rec_t mk_rec(input logic [FieldW-1:0] bat, input logic [FieldW-1:0] tmp,
                                  input logic [FieldW-1:0] lat, input logic [FieldW-1:0] lon,
                                  input logic [FieldW-1:0] vol, input logic [FieldW-1:0] ang);
    rec_t r;
    r.battery_level     = bat;
    r.temperature_value = tmp;
    r.latitude_value    = lat;
    r.longitude_value   = lon;
    r.volume_value      = vol;
    r.angle_value       = ang;
    return r;
  endfunction

  // value with a random number of significant hex digits, sometimes fully random
  function automatic logic [FieldW-1:0] rand_value();
    int unsigned len;
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 9) < 2) begin
      return raw[FieldW-1:0];
    end
    len = $urandom_range(0, 6);
    return (len == 0) ? '0 : FieldW'(raw & ((32'd1 << (4 * len)) - 1));
  endfunction

  function automatic logic [FieldW-1:0] rand_small_field();
    if ($urandom_range(0, 9) < 7) begin
      return FieldW'($urandom_range(0, 255));
    end
    return rand_value();
  endfunction

  function automatic rec_t rand_rec();
    return mk_rec(rand_small_field(), rand_small_field(), rand_value(), rand_value(),
                  rand_value(), rand_value());
  endfunction

  function automatic int sender_gap();
    int p;
    if (quiet) begin
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 55) begin
      return 0;
    end else if (p < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 40);
  endfunction

  // one record transfer; called at a falling edge, returns at a falling edge
  task automatic send_record(input rec_t r, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    quiet    = 1'b0;
    hold_go  = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corner records
    send_record(mk_rec('0, '0, '0, '0, '0, '0), sender_gap());
    send_record(mk_rec('1, '1, '1, '1, '1, '1), sender_gap());
    send_record(mk_rec(24'hFF, 24'hFF, 24'hFFFFFF, 24'h0, 24'h1, 24'hF), sender_gap());
    send_record(mk_rec(24'h100, 24'h100, 24'h000001, 24'h100000, 24'h10, 24'h100),
                sender_gap());
    send_record(mk_rec(24'h800000, 24'h0000FF, 24'hABCDEF, 24'h012345, 24'hFFFFF,
                       24'h100000), sender_gap());
    send_record(mk_rec(24'h0, 24'h800000, 24'h123456, 24'hFEDCBA, 24'h0, 24'hFFFFFF),
                sender_gap());
    send_record(mk_rec(24'h0A, 24'hA0, 24'h00000F, 24'hF00000, 24'hFFFF, 24'hFFF),
                sender_gap());
    send_record(mk_rec(24'h01, 24'h10, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA),
                sender_gap());
    send_record(mk_rec(24'hAAAAAA, 24'h555555, 24'h999999, 24'h666666, 24'h9, 24'hA),
                sender_gap());
    send_record(mk_rec(24'h1FF, 24'h0FF, 24'h0, 24'hFFFFFF, 24'h0, 24'h1), sender_gap());
    for (int i = 0; i < 24; i += 4) begin
      send_record(mk_rec(FieldW'(1) << i, FieldW'(1) << (23 - i), FieldW'(1) << i,
                         FieldW'(1) << (23 - i), FieldW'(1) << i, FieldW'(1) << (23 - i)),
                  sender_gap());
    end

    for (int n = 0; n < 150; n++) begin
      send_record(rand_rec(), sender_gap());
    end

    quiet = 1'b1;
    for (int n = 0; n < 60; n++) begin
      send_record(rand_rec(), 0);
    end
    quiet = 1'b0;

    // long receiver hold while records keep coming
    hold_go = 1'b1;
    for (int n = 0; n < 12; n++) begin
      send_record(rand_rec(), 0);
    end
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    for (int n = 0; n < RandomRecords - 222; n++) begin
      send_record(rand_rec(), sender_gap());
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/srhf_pkg.sv
rtl/core/srhf_front.sv
rtl/core/srhf_queue.sv
rtl/core/srhf_back.sv
rtl/core/sensor_report_hex_framer.sv
bench/srhf_frame_checker.sv
bench/sensor_report_hex_framer_test.sv
